[hw/rtl/swts_pkg.sv]
// Shared types and codes for the stop-and-wait transport server
`timescale 1ns / 1ps
package swts_pkg;

	typedef enum logic [2:0] {
		OP_OPEN    = 3'd0,
		OP_LISTEN  = 3'd1,
		OP_ARRIVE  = 3'd2,
		OP_CONSUME = 3'd3,
		OP_CLOSE   = 3'd4
	} op_code_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_SHORT   = 3'd2,
		ST_DROPPED = 3'd3,
		ST_BAD     = 3'd4
	} status_code_t;

	typedef enum logic [1:0] {
		CS_CLOSED    = 2'd0,
		CS_LISTENING = 2'd1,
		CS_CONNECTED = 2'd2,
		CS_CLOSEWAIT = 2'd3
	} conn_state_t;

	localparam logic [1:0] SEG_SYN  = 2'd0;
	localparam logic [1:0] SEG_FIN  = 2'd1;
	localparam logic [1:0] SEG_DATA = 2'd2;

	localparam logic [1:0] RK_SYNACK  = 2'd0;
	localparam logic [1:0] RK_FINACK  = 2'd1;
	localparam logic [1:0] RK_DATAACK = 2'd2;

	localparam logic [31:0] INITIAL_SEQ = 32'd10;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_EXEC,
		FSM_OUT
	} fsm_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic scan_step;
		logic exec;
		logic out_load;
	} swts_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_scan;
		logic scan_done;
	} swts_sts_t;

endpackage

[hw/rtl/stop_and_wait_transport_server.sv]
// Top level of the stop-and-wait transport server
`timescale 1ns / 1ps
// Connection table for a simple transport server. One request at a time: open and
// segment arrival walk the table one entry per cycle, so their time grows with
// NUM_SOCKETS, and the table scan sets the worst case. A finished result sits in an
// output register until it is taken; the next request may be accepted meanwhile.
module stop_and_wait_transport_server
	import swts_pkg::*;
#(
	parameter int NUM_SOCKETS = 10,
	parameter int SEG_BYTES   = 512,
	parameter int BUF_BYTES   = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [3:0]  sock_index,
	input  logic [15:0] local_port,
	input  logic [15:0] peer_port,
	input  logic [1:0]  seg_kind,
	input  logic [31:0] seq_in,
	input  logic [7:0]  peer_node,
	input  logic [12:0] want_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  sock_out,
	output logic [1:0]  conn_state,
	output logic [12:0] buffered_bytes,
	output logic        reply_valid,
	output logic [1:0]  reply_kind,
	output logic [15:0] reply_src_port,
	output logic [15:0] reply_dst_port,
	output logic [31:0] reply_ack,
	output logic [7:0]  reply_node
);

	swts_cmd_t cmd;
	swts_sts_t sts;

	swts_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_stall, .out_valid,
		.sts, .cmd
	);

	swts_datapath #(
		.NUM_SOCKETS(NUM_SOCKETS), .SEG_BYTES(SEG_BYTES), .BUF_BYTES(BUF_BYTES)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.op, .sock_index, .local_port, .peer_port, .seg_kind, .seq_in,
		.peer_node, .want_bytes,
		.status, .sock_out, .conn_state, .buffered_bytes, .reply_valid,
		.reply_kind, .reply_src_port, .reply_dst_port, .reply_ack, .reply_node
	);

endmodule

[hw/rtl/swts_ctrl.sv]
// Controller state machine for the stop-and-wait transport server
`timescale 1ns / 1ps
module swts_ctrl
	import swts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      out_stall,
	output logic      out_valid,
	input  swts_sts_t sts,
	output swts_cmd_t cmd
);

	fsm_state_t state_q, state_d;
	logic       out_valid_q;

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != FSM_IDLE);

	// Sequence one request: scan, execute, then publish the result
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (!sts.need_scan || sts.scan_done)
					state_d = FSM_EXEC;
				else
					cmd.scan_step = 1'b1;
			end
			FSM_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = FSM_OUT;
			end
			FSM_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

endmodule

[hw/rtl/swts_datapath.sv]
// Connection table and result logic for the stop-and-wait transport server
`timescale 1ns / 1ps
module swts_datapath
	import swts_pkg::*;
#(
	parameter int NUM_SOCKETS = 10,
	parameter int SEG_BYTES   = 512,
	parameter int BUF_BYTES   = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  swts_cmd_t   cmd,
	output swts_sts_t   sts,
	input  logic [2:0]  op,
	input  logic [3:0]  sock_index,
	input  logic [15:0] local_port,
	input  logic [15:0] peer_port,
	input  logic [1:0]  seg_kind,
	input  logic [31:0] seq_in,
	input  logic [7:0]  peer_node,
	input  logic [12:0] want_bytes,
	output logic [2:0]  status,
	output logic [3:0]  sock_out,
	output logic [1:0]  conn_state,
	output logic [12:0] buffered_bytes,
	output logic        reply_valid,
	output logic [1:0]  reply_kind,
	output logic [15:0] reply_src_port,
	output logic [15:0] reply_dst_port,
	output logic [31:0] reply_ack,
	output logic [7:0]  reply_node
);

	localparam int IW = (NUM_SOCKETS > 1) ? $clog2(NUM_SOCKETS) : 1;
	localparam logic [13:0] SEG14 = 14'(SEG_BYTES);
	localparam logic [13:0] BUF14 = 14'(BUF_BYTES);

	// Request registers
	logic [2:0]  op_q;
	logic [3:0]  idx_q;
	logic [15:0] lport_q, pport_q;
	logic [1:0]  kind_q;
	logic [31:0] seq_q;
	logic [7:0]  node_q;
	logic [12:0] want_q;

	// Table
	logic [NUM_SOCKETS-1:0] used_q;
	conn_state_t            cst_q [NUM_SOCKETS];
	logic [15:0]            sport_q [NUM_SOCKETS];
	logic [15:0]            cport_q [NUM_SOCKETS];
	logic [31:0]            eseq_q [NUM_SOCKETS];
	logic [12:0]            ubytes_q [NUM_SOCKETS];

	// Scan state
	logic [IW:0] scan_q;
	logic        found_q;
	logic [IW-1:0] hit_q;

	// Result registers
	logic [2:0]  res_status_q;
	logic [3:0]  res_sock_q;
	logic [1:0]  res_cst_q;
	logic [12:0] res_buf_q;
	logic        res_rv_q;
	logic [1:0]  res_rk_q;
	logic [15:0] res_sp_q, res_dp_q;
	logic [31:0] res_ack_q;
	logic [7:0]  res_node_q;

	logic scan_end, scan_hit;
	assign scan_end = (scan_q >= (IW+1)'(NUM_SOCKETS));
	assign scan_hit = !scan_end && used_q[scan_q[IW-1:0]] &&
		(op_q == OP_OPEN ? 1'b1 : (sport_q[scan_q[IW-1:0]] == lport_q));

	assign sts.need_scan = (op_q == OP_OPEN) || (op_q == OP_ARRIVE);
	assign sts.scan_done = scan_end || found_q;

	// Latch request, walk the table one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			found_q <= 1'b0;
			hit_q   <= '0;
		end else if (cmd.load) begin
			scan_q  <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step && !found_q) begin
			if (op_q == OP_OPEN ? (!scan_end && !used_q[scan_q[IW-1:0]]) : scan_hit) begin
				found_q <= 1'b1;
				hit_q   <= scan_q[IW-1:0];
			end else begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			idx_q   <= sock_index;
			lport_q <= local_port;
			pport_q <= peer_port;
			kind_q  <= seg_kind;
			seq_q   <= seq_in;
			node_q  <= peer_node;
			want_q  <= want_bytes;
		end
	end

	// Execute step: resolve entry and compute the new entry values
	logic        idx_ok;
	logic [IW-1:0] e;
	logic        have_e;
	logic [2:0]  n_status;
	conn_state_t n_cst;
	logic [12:0] n_ub;
	logic [31:0] n_eseq;
	logic [15:0] n_cport, n_sport;
	logic        n_used, wr_e;
	logic        n_rv;
	logic [1:0]  n_rk;
	logic [31:0] n_ack;
	logic [13:0] segs_up, rm;

	assign idx_ok = ({1'b0, idx_q} < 5'(NUM_SOCKETS)) && used_q[idx_q[IW-1:0]];

	always_comb begin
		e        = hit_q;
		have_e   = 1'b0;
		n_status = ST_OK;
		wr_e     = 1'b0;
		n_rv     = 1'b0;
		n_rk     = RK_SYNACK;
		n_ack    = '0;
		segs_up  = 14'({1'b0, want_q} + SEG14 - 14'd1);
		rm       = (segs_up / SEG14) * SEG14;
		n_used   = 1'b0;
		n_cst    = CS_CLOSED;
		n_ub     = '0;
		n_eseq   = '0;
		n_cport  = '0;
		n_sport  = '0;
		case (op_q)
			OP_OPEN, OP_ARRIVE: e = hit_q;
			default:            e = idx_q[IW-1:0];
		endcase
		n_used  = used_q[e];
		n_cst   = cst_q[e];
		n_ub    = ubytes_q[e];
		n_eseq  = eseq_q[e];
		n_cport = cport_q[e];
		n_sport = sport_q[e];
		unique case (op_q)
			OP_OPEN: begin
				if (!found_q) n_status = ST_FULL;
				else begin
					have_e = 1'b1; wr_e = 1'b1; n_used = 1'b1; n_cst = CS_CLOSED;
					n_sport = lport_q; n_cport = '0; n_eseq = INITIAL_SEQ; n_ub = '0;
				end
			end
			OP_ARRIVE: begin
				if (!found_q) n_status = ST_DROPPED;
				else begin
					have_e = 1'b1; wr_e = 1'b1;
					case (cst_q[e])
						CS_LISTENING: if (kind_q == SEG_SYN) begin
							n_cport = pport_q; n_rv = 1'b1; n_rk = RK_SYNACK;
							n_cst = CS_CONNECTED;
						end
						CS_CONNECTED: begin
							if (kind_q == SEG_SYN) begin
								n_eseq = seq_q; n_rv = 1'b1; n_rk = RK_SYNACK;
							end else if (kind_q == SEG_FIN) begin
								n_rv = 1'b1; n_rk = RK_FINACK; n_cst = CS_CLOSEWAIT;
							end else if (kind_q == SEG_DATA) begin
								if ({1'b0, ubytes_q[e]} + SEG14 < BUF14) begin
									if (eseq_q[e] == seq_q) begin
										n_ub   = 13'({1'b0, ubytes_q[e]} + SEG14);
										n_eseq = eseq_q[e] + 32'd1;
									end
									n_rv = 1'b1; n_rk = RK_DATAACK; n_ack = n_eseq;
								end
							end
						end
						CS_CLOSEWAIT: if (kind_q == SEG_FIN) begin
							n_rv = 1'b1; n_rk = RK_FINACK;
						end
						default: ;
					endcase
				end
			end
			OP_LISTEN, OP_CONSUME, OP_CLOSE: begin
				if (!idx_ok) n_status = ST_BAD;
				else begin
					have_e = 1'b1; wr_e = 1'b1;
					if (op_q == OP_LISTEN) n_cst = CS_LISTENING;
					else if (op_q == OP_CONSUME) begin
						if (want_q > ubytes_q[e]) n_status = ST_SHORT;
						else if (rm >= {1'b0, ubytes_q[e]}) n_ub = '0;
						else n_ub = 13'({1'b0, ubytes_q[e]} - rm);
					end else begin
						n_used = 1'b0; n_cst = CS_CLOSED; n_ub = '0;
					end
				end
			end
			default: n_status = ST_BAD;
		endcase
	end

	// Commit entry update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < NUM_SOCKETS; i++) cst_q[i] <= CS_CLOSED;
		end else if (cmd.exec && wr_e) begin
			used_q[e] <= n_used;
			cst_q[e]  <= n_cst;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_e) begin
			sport_q[e]  <= n_sport;
			cport_q[e]  <= n_cport;
			eseq_q[e]   <= n_eseq;
			ubytes_q[e] <= n_ub;
		end
	end

	// Capture result
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= n_status;
			res_sock_q   <= have_e ? 4'(e) : 4'd0;
			res_cst_q    <= have_e ? n_cst : 2'd0;
			res_buf_q    <= have_e ? n_ub : 13'd0;
			res_rv_q     <= n_rv;
			res_rk_q     <= n_rv ? n_rk : 2'd0;
			res_sp_q     <= n_rv ? n_sport : 16'd0;
			res_dp_q     <= n_rv ? n_cport : 16'd0;
			res_ack_q    <= n_rv ? n_ack : 32'd0;
			res_node_q   <= n_rv ? node_q : 8'd0;
		end
	end

	// Output register, loaded when the controller publishes
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status         <= res_status_q;
			sock_out       <= res_sock_q;
			conn_state     <= res_cst_q;
			buffered_bytes <= res_buf_q;
			reply_valid    <= res_rv_q;
			reply_kind     <= res_rk_q;
			reply_src_port <= res_sp_q;
			reply_dst_port <= res_dp_q;
			reply_ack      <= res_ack_q;
			reply_node     <= res_node_q;
		end
	end

endmodule

[hw/rtl/swts_checker.sv]
// Port-level checks for the stop-and-wait transport server
`timescale 1ns / 1ps
module swts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic        reply_valid,
	input logic [1:0]  reply_kind,
	input logic [31:0] reply_ack
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");

	// No request taken in the cycle after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request accepted too early");

	// Replies come only with ok status
	a_reply_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_valid |-> status == 3'd0)
		else $error("reply with error status");

	// Only data acks carry an acknowledgement number
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_kind != 2'd2 |-> reply_ack == 32'd0)
		else $error("ack set on non-data reply");

endmodule

bind stop_and_wait_transport_server swts_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.status, .reply_valid, .reply_kind, .reply_ack
);
